/* hw/rtl/cpuvm_pkg.sv */
// Shared types, constants and helper functions for the camera pose block.
`default_nettype none
package cpuvm_pkg;

	// Request and result payloads
	typedef struct packed {
		logic [3:0]  req_type;
		logic [15:0] elapsed;
	} req_t;

	typedef struct packed {
		logic signed [15:0] out_right_x;
		logic signed [15:0] out_right_y;
		logic signed [15:0] out_right_z;
		logic signed [15:0] out_down_x;
		logic signed [15:0] out_down_y;
		logic signed [15:0] out_down_z;
		logic signed [15:0] out_fwd_x;
		logic signed [15:0] out_fwd_y;
		logic signed [15:0] out_fwd_z;
		logic signed [31:0] shift_right;
		logic signed [31:0] shift_down;
		logic signed [31:0] shift_fwd;
	} rsp_t;

	// Move codes
	localparam logic [3:0] MV_FWD     = 4'd0;
	localparam logic [3:0] MV_LEFT    = 4'd1;
	localparam logic [3:0] MV_RIGHT   = 4'd2;
	localparam logic [3:0] MV_BACK    = 4'd3;
	localparam logic [3:0] MV_UP      = 4'd4;
	localparam logic [3:0] MV_DOWN    = 4'd5;
	localparam logic [3:0] MV_TURN_L  = 4'd6;
	localparam logic [3:0] MV_TURN_R  = 4'd7;
	localparam logic [3:0] MV_LOOK_UP = 4'd8;
	localparam logic [3:0] MV_LOOK_DN = 4'd9;
	localparam logic [3:0] MV_ROLL_L  = 4'd10;
	localparam logic [3:0] MV_ROLL_R  = 4'd11;

	// Register index
	localparam logic REG_SPEED = 1'b0;
	localparam logic [15:0] SPEED_RST = 16'd256;

	// Axis roles
	localparam logic [1:0] AX_RIGHT = 2'd0;
	localparam logic [1:0] AX_DOWN  = 2'd1;
	localparam logic [1:0] AX_FWD   = 2'd2;

	// Fixed-point constants
	localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
	localparam int TWO_PI_Q16  = 411775;
	localparam int PI_Q16      = 205887;
	localparam int HALF_PI_Q16 = 102944;
	localparam int CORDIC_K_Q30 = 652032874;

	// Arctangent table in Q16 radians
	function automatic logic [15:0] atan_q16(input logic [3:0] i);
		logic [15:0] r;
		unique case (i)
			4'd0:  r = 16'd51472;
			4'd1:  r = 16'd30386;
			4'd2:  r = 16'd16055;
			4'd3:  r = 16'd8150;
			4'd4:  r = 16'd4091;
			4'd5:  r = 16'd2047;
			4'd6:  r = 16'd1024;
			4'd7:  r = 16'd512;
			4'd8:  r = 16'd256;
			4'd9:  r = 16'd128;
			4'd10: r = 16'd64;
			4'd11: r = 16'd32;
			4'd12: r = 16'd16;
			4'd13: r = 16'd8;
			4'd14: r = 16'd4;
			default: r = 16'd2;
		endcase
		return r;
	endfunction

	// Clamp to +-1.0 in Q1.14
	function automatic logic signed [15:0] sat14(input logic signed [47:0] x);
		logic signed [15:0] r;
		if (x > 48'sd16384) r = ONE_Q14;
		else if (x < -48'sd16384) r = -ONE_Q14;
		else r = x[15:0];
		return r;
	endfunction

	// Clamp to the 32 bit signed range
	function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
		logic signed [31:0] r;
		if (x > 48'sd2147483647) r = 32'sh7fffffff;
		else if (x < -48'sd2147483648) r = 32'sh80000000;
		else r = x[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/cpuvm_cordic.sv */
// Iterative CORDIC unit: one rotation step per cycle, sine and cosine in Q1.14.
`default_nettype none
module cpuvm_cordic (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [19:0] z_in,
	input  wire logic               neg,
	output logic                    done,
	output logic signed [15:0]      cos_val,
	output logic signed [15:0]      sin_val
);
	import cpuvm_pkg::*;

	logic signed [33:0] x_q, y_q;
	logic signed [19:0] z_q;
	logic [3:0]         i_q;
	logic               busy_q, done_q, neg_q;
	logic signed [33:0] dx, dy;
	logic signed [34:0] xr, xs, ys;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= 4'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= 4'd0;
			end else if (busy_q) begin
				i_q <= i_q + 4'd1;
				if (i_q == 4'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Rotate one step toward zero residual angle
	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= 34'(CORDIC_K_Q30);
			y_q   <= 34'sd0;
			z_q   <= z_in;
			neg_q <= neg;
		end else if (busy_q) begin
			if (z_q >= 20'sd0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - $signed({4'b0, atan_q16(i_q)});
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + $signed({4'b0, atan_q16(i_q)});
			end
		end
	end

	// Round Q30 down to Q1.14 and clamp
	assign xr = neg_q ? -35'(x_q) : 35'(x_q);
	assign xs = (xr + 35'sd32768) >>> 16;
	assign ys = (35'(y_q) + 35'sd32768) >>> 16;
	assign cos_val = sat14(48'(xs));
	assign sin_val = sat14(48'(ys));
	assign done = done_q;

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("cordic restarted while busy");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(i_q) == 4'd15) else $error("cordic finished early");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("cordic done while busy");
`endif

endmodule
`default_nettype wire

/* hw/rtl/cpuvm_sqrt.sv */
// Bit-serial integer square root: one result bit per cycle.
`default_nettype none
module cpuvm_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [43:0] val,
	output logic             done,
	output logic [21:0]      root
);
	logic [43:0] rem_q, bit_q;
	logic [44:0] res_q, trial;
	logic [4:0]  cnt_q;
	logic        busy_q, done_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd21) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Try the next bit pair
	assign trial = res_q + {1'b0, bit_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= val;
			res_q <= 45'd0;
			bit_q <= 44'd1 << 42;
		end else if (busy_q) begin
			if ({1'b0, rem_q} >= trial) begin
				rem_q <= rem_q - trial[43:0];
				res_q <= (res_q >> 1) + {1'b0, bit_q};
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[21:0];
	assign done = done_q;

endmodule
`default_nettype wire

/* hw/rtl/cpuvm_div.sv */
// Restoring unsigned divider: one quotient bit per cycle.
`default_nettype none
module cpuvm_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [35:0] num,
	input  wire logic [21:0] den,
	output logic             done,
	output logic [35:0]      quot
);
	logic [21:0] rem_q, den_q;
	logic [35:0] q_q;
	logic [22:0] r2;
	logic        ge;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd35) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in one numerator bit, subtract if it fits
	assign r2 = {rem_q, q_q[35]};
	assign ge = r2 >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= 22'd0;
			q_q   <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? 22'(r2 - {1'b0, den_q}) : r2[21:0];
			q_q   <= {q_q[34:0], ge};
		end
	end

	assign quot = q_q;
	assign done = done_q;

endmodule
`default_nettype wire

/* hw/rtl/camera_pose_update_view_matrix.sv */
// Top level: camera pose registers, sequencer, shared multiplier and view matrix output.
`default_nettype none
// Free-fly camera pose. Each request carries a move code and an elapsed time;
// the block updates its position or axes and returns one view matrix (three
// Q1.14 axes and three Q16.16 translations). One request is worked at a time
// and req_stall stays high until the result has been taken. All products go
// through one registered 24x33 multiplier, stepped by the sequencer. Every
// request ends in the nine dot-product multiplies; a translation first
// moves the position along one axis. A turn, look or roll first runs 16
// CORDIC steps, a square root and three divides for the renormalization.
// The speed register is written at byte address 0 of the APB port and is
// read back there.
module camera_pose_update_view_matrix (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             req_valid,
	output logic                  req_stall,
	input  wire cpuvm_pkg::req_t  req,
	output logic                  rsp_valid,
	input  wire logic             rsp_stall,
	output cpuvm_pkg::rsp_t       rsp,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import cpuvm_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_AMT  = 5'd1;
	localparam logic [4:0] S_AMT2 = 5'd2;
	localparam logic [4:0] S_MOD  = 5'd3;
	localparam logic [4:0] S_FOLD = 5'd4;
	localparam logic [4:0] S_CORD = 5'd5;
	localparam logic [4:0] S_RA   = 5'd6;
	localparam logic [4:0] S_RB   = 5'd7;
	localparam logic [4:0] S_RC   = 5'd8;
	localparam logic [4:0] S_RSQ  = 5'd9;
	localparam logic [4:0] S_RACC = 5'd10;
	localparam logic [4:0] S_SQS  = 5'd11;
	localparam logic [4:0] S_SQW  = 5'd12;
	localparam logic [4:0] S_DVS  = 5'd13;
	localparam logic [4:0] S_DVW  = 5'd14;
	localparam logic [4:0] S_XA0  = 5'd15;
	localparam logic [4:0] S_XA1  = 5'd16;
	localparam logic [4:0] S_XB   = 5'd17;
	localparam logic [4:0] S_XC   = 5'd18;
	localparam logic [4:0] S_XD   = 5'd19;
	localparam logic [4:0] S_TMUL = 5'd20;
	localparam logic [4:0] S_TADD = 5'd21;
	localparam logic [4:0] S_DMUL = 5'd22;
	localparam logic [4:0] S_DACC = 5'd23;
	localparam logic [4:0] S_DFIN = 5'd24;
	localparam logic [4:0] S_OUT  = 5'd25;

	// Sequencer and architectural state
	logic [4:0]         state_q;
	logic [1:0]         cnt_q, k_q;
	logic [2:0]         mk_q;
	logic [3:0]         typ_q;
	logic [15:0]        speed_q;
	logic signed [15:0] ax_q [3][3];
	logic signed [31:0] pos_q [3];

	// Datapath registers
	logic [15:0]        elap_q;
	logic [23:0]        amt_q, z_q;
	logic signed [15:0] c_q, sv_q;
	logic signed [47:0] acc_q;
	logic signed [22:0] v_q [3];
	logic [43:0]        sum_q;
	logic [21:0]        mag_q;
	logic signed [32:0] tmp_q;
	logic signed [31:0] sh_q [3];
	logic signed [56:0] p_q;

	// Combinational
	logic signed [23:0] mul_a;
	logic signed [32:0] mul_b;
	logic [1:0]         rd_role, rd_comp;
	logic signed [15:0] rd_val;
	logic [1:0]         rot_a, rot_b, rot_q, tr_ax;
	logic               tr_sub;
	logic [23:0]        mod_lim;
	logic signed [20:0] zw, zs, fz;
	logic               fneg;
	logic               cord_done, sq_done, dv_done;
	logic signed [15:0] cord_c, cord_s;
	logic [21:0]        sq_root;
	logic [35:0]        dv_quot, dv_num;
	logic [22:0]        vabs;
	logic [15:0]        qs;
	logic signed [15:0] ax_new, x_new;
	logic signed [47:0] pd, vsum, vr, td, tpos, xv, dv;
	logic               cfg_wr;

	function automatic logic [1:0] nxt(input logic [1:0] j);
		return (j == 2'd2) ? 2'd0 : j + 2'd1;
	endfunction

	// Axis roles for each move group
	always_comb begin
		rot_a = AX_RIGHT;
		rot_b = AX_FWD;
		rot_q = AX_DOWN;
		if (typ_q == MV_LOOK_UP || typ_q == MV_LOOK_DN) begin
			rot_a = AX_FWD;
			rot_b = AX_DOWN;
			rot_q = AX_RIGHT;
		end else if (typ_q == MV_ROLL_L || typ_q == MV_ROLL_R) begin
			rot_a = AX_DOWN;
			rot_b = AX_RIGHT;
			rot_q = AX_FWD;
		end
		tr_ax  = AX_FWD;
		if (typ_q == MV_LEFT || typ_q == MV_RIGHT) tr_ax = AX_RIGHT;
		else if (typ_q == MV_UP || typ_q == MV_DOWN) tr_ax = AX_DOWN;
		tr_sub = (typ_q == MV_LEFT) || (typ_q == MV_BACK) || (typ_q == MV_UP);
	end

	// Select the axis entry and multiplier operands for this step
	always_comb begin
		rd_role = AX_RIGHT;
		rd_comp = cnt_q;
		mul_a   = 24'sd0;
		mul_b   = 33'sd0;
		unique case (state_q)
			S_AMT: begin
				mul_a = $signed({8'b0, speed_q});
				mul_b = $signed({17'b0, elap_q});
			end
			S_TMUL: begin
				rd_role = tr_ax;
				mul_a   = 24'(rd_val);
				mul_b   = $signed({9'b0, amt_q});
			end
			S_RA: begin
				rd_role = rot_a;
				mul_a   = 24'(rd_val);
				mul_b   = 33'(c_q);
			end
			S_RB: begin
				rd_role = rot_b;
				mul_a   = 24'(rd_val);
				mul_b   = 33'(sv_q);
			end
			S_RSQ: begin
				mul_a = 24'(v_q[cnt_q]);
				mul_b = 33'(v_q[cnt_q]);
			end
			S_XA0: begin
				rd_role = rot_a;
				rd_comp = nxt(cnt_q);
			end
			S_XA1: begin
				rd_role = rot_q;
				rd_comp = nxt(nxt(cnt_q));
				mul_a   = 24'(rd_val);
				mul_b   = tmp_q;
			end
			S_XB: begin
				rd_role = rot_a;
				rd_comp = nxt(nxt(cnt_q));
			end
			S_XC: begin
				rd_role = rot_q;
				rd_comp = nxt(cnt_q);
				mul_a   = 24'(rd_val);
				mul_b   = tmp_q;
			end
			S_DMUL: begin
				rd_role = k_q;
				mul_a   = 24'(rd_val);
				mul_b   = 33'(pos_q[cnt_q]);
			end
			default: begin
			end
		endcase
	end

	assign rd_val = ax_q[rd_role][rd_comp];

	// Angle reduction: one compare-subtract per cycle, then fold into +-pi/2
	assign mod_lim = 24'(TWO_PI_Q16) << mk_q;
	always_comb begin
		zw   = $signed({2'b0, z_q[18:0]});
		zs   = (zw > 21'sd205887) ? zw - 21'sd411775 : zw;
		fz   = zs;
		fneg = 1'b0;
		if (zs > 21'(HALF_PI_Q16)) begin
			fz   = 21'(PI_Q16) - zs;
			fneg = 1'b1;
		end else if (zs < -21'(HALF_PI_Q16)) begin
			fz   = -21'(PI_Q16) - zs;
			fneg = 1'b1;
		end
	end

	cpuvm_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == S_FOLD),
		.z_in    (fz[19:0]),
		.neg     (fneg),
		.done    (cord_done),
		.cos_val (cord_c),
		.sin_val (cord_s)
	);

	cpuvm_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_SQS),
		.val    (sum_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	// Normalize: (|v| * 2^14 + mag/2) / mag
	assign vabs   = v_q[cnt_q][22] ? 23'(-v_q[cnt_q]) : v_q[cnt_q];
	assign dv_num = {vabs[21:0], 14'b0} + {15'b0, mag_q[21:1]};

	cpuvm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_DVS),
		.num    (dv_num),
		.den    (mag_q),
		.done   (dv_done),
		.quot   (dv_quot)
	);

	assign qs     = (dv_quot > 36'd16384) ? 16'd16384 : dv_quot[15:0];
	assign ax_new = v_q[cnt_q][22] ? -$signed(qs) : $signed(qs);

	// Rounding and saturation of the product paths
	assign pd   = $signed(p_q[47:0]);
	assign vsum = acc_q + pd;
	assign vr   = (vsum + 48'sd128) >>> 8;
	assign td   = (pd + 48'sd8192) >>> 14;
	assign tpos = tr_sub ? 48'(pos_q[cnt_q]) - td : 48'(pos_q[cnt_q]) + td;
	assign xv   = (acc_q - pd + 48'sd8192) >>> 14;
	assign x_new = sat14(xv);
	assign dv   = -((acc_q + 48'sd8192) >>> 14);

	assign cfg_wr = psel && penable && pwrite;

	// Sequencer and pose state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= 2'd0;
			k_q     <= 2'd0;
			mk_q    <= 3'd0;
			typ_q   <= 4'd0;
			speed_q <= SPEED_RST;
			for (int r = 0; r < 3; r++) begin
				pos_q[r] <= 32'sd0;
				for (int c = 0; c < 3; c++)
					ax_q[r][c] <= (r == c) ? ONE_Q14 : 16'sd0;
			end
		end else begin
			if (cfg_wr && paddr[2] == REG_SPEED) speed_q <= pwdata[15:0];
			unique case (state_q)
				S_IDLE: if (req_valid) begin
					typ_q   <= req.req_type;
					state_q <= S_AMT;
				end
				S_AMT: state_q <= S_AMT2;
				S_AMT2: begin
					cnt_q <= 2'd0;
					k_q   <= 2'd0;
					mk_q  <= 3'd5;
					if (typ_q <= MV_DOWN) state_q <= S_TMUL;
					else if (typ_q <= MV_ROLL_R) state_q <= S_MOD;
					else state_q <= S_DMUL;
				end
				S_MOD: begin
					if (mk_q == 3'd0) state_q <= S_FOLD;
					else mk_q <= mk_q - 3'd1;
				end
				S_FOLD: state_q <= S_CORD;
				S_CORD: if (cord_done) begin
					cnt_q   <= 2'd0;
					state_q <= S_RA;
				end
				S_RA:  state_q <= S_RB;
				S_RB:  state_q <= S_RC;
				S_RC:  state_q <= S_RSQ;
				S_RSQ: state_q <= S_RACC;
				S_RACC: begin
					if (cnt_q == 2'd2) state_q <= S_SQS;
					else begin
						cnt_q   <= cnt_q + 2'd1;
						state_q <= S_RA;
					end
				end
				S_SQS: state_q <= S_SQW;
				S_SQW: if (sq_done) begin
					cnt_q <= 2'd0;
					// Zero magnitude: leave the axes alone
					state_q <= (sq_root == 22'd0) ? S_DMUL : S_DVS;
				end
				S_DVS: state_q <= S_DVW;
				S_DVW: if (dv_done) begin
					ax_q[rot_a][cnt_q] <= ax_new;
					if (cnt_q == 2'd2) begin
						cnt_q   <= 2'd0;
						state_q <= S_XA0;
					end else begin
						cnt_q   <= cnt_q + 2'd1;
						state_q <= S_DVS;
					end
				end
				S_XA0: state_q <= S_XA1;
				S_XA1: state_q <= S_XB;
				S_XB:  state_q <= S_XC;
				S_XC:  state_q <= S_XD;
				S_XD: begin
					ax_q[rot_b][cnt_q] <= x_new;
					if (cnt_q == 2'd2) begin
						cnt_q   <= 2'd0;
						state_q <= S_DMUL;
					end else begin
						cnt_q   <= cnt_q + 2'd1;
						state_q <= S_XA0;
					end
				end
				S_TMUL: state_q <= S_TADD;
				S_TADD: begin
					pos_q[cnt_q] <= sat32(tpos);
					if (cnt_q == 2'd2) begin
						cnt_q   <= 2'd0;
						state_q <= S_DMUL;
					end else begin
						cnt_q   <= cnt_q + 2'd1;
						state_q <= S_TMUL;
					end
				end
				S_DMUL: state_q <= S_DACC;
				S_DACC: begin
					if (cnt_q == 2'd2) state_q <= S_DFIN;
					else begin
						cnt_q   <= cnt_q + 2'd1;
						state_q <= S_DMUL;
					end
				end
				S_DFIN: begin
					cnt_q <= 2'd0;
					if (k_q == 2'd2) state_q <= S_OUT;
					else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_DMUL;
					end
				end
				S_OUT: if (!rsp_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Shared multiplier and datapath registers
	always_ff @(posedge clk) begin
		p_q <= 57'(mul_a) * 57'(mul_b);
		unique case (state_q)
			S_IDLE: elap_q <= req.elapsed;
			S_AMT2: begin
				amt_q <= p_q[31:8];
				z_q   <= p_q[31:8];
			end
			S_MOD: if (z_q >= mod_lim) z_q <= z_q - mod_lim;
			S_CORD: if (cord_done) begin
				c_q <= cord_c;
				if (typ_q == MV_TURN_L || typ_q == MV_LOOK_DN || typ_q == MV_ROLL_L)
					sv_q <= cord_s;
				else
					sv_q <= -cord_s;
			end
			S_RB:   acc_q <= pd;
			S_RC:   v_q[cnt_q] <= vr[22:0];
			S_RACC: sum_q <= ((cnt_q == 2'd0) ? 44'd0 : sum_q) + p_q[43:0];
			S_SQW:  if (sq_done) mag_q <= sq_root;
			S_XA0:  tmp_q <= 33'(rd_val);
			S_XB: begin
				acc_q <= pd;
				tmp_q <= 33'(rd_val);
			end
			S_DACC: acc_q <= ((cnt_q == 2'd0) ? 48'sd0 : acc_q) + pd;
			S_DFIN: sh_q[k_q] <= sat32(dv);
			default: begin
			end
		endcase
	end

	// Handshakes and result
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = (state_q == S_OUT);
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_SPEED) ? {16'b0, speed_q} : 32'd0;

	always_comb begin
		rsp.out_right_x = ax_q[AX_RIGHT][0];
		rsp.out_right_y = ax_q[AX_RIGHT][1];
		rsp.out_right_z = ax_q[AX_RIGHT][2];
		rsp.out_down_x  = ax_q[AX_DOWN][0];
		rsp.out_down_y  = ax_q[AX_DOWN][1];
		rsp.out_down_z  = ax_q[AX_DOWN][2];
		rsp.out_fwd_x   = ax_q[AX_FWD][0];
		rsp.out_fwd_y   = ax_q[AX_FWD][1];
		rsp.out_fwd_z   = ax_q[AX_FWD][2];
		rsp.shift_right = sh_q[0];
		rsp.shift_down  = sh_q[1];
		rsp.shift_fwd   = sh_q[2];
	end

`ifndef SYNTHESIS
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_AMT)) else $error("request not started");
	a_cord: assert property (@(posedge clk) disable iff (!arst_n)
		cord_done |-> (state_q == S_CORD)) else $error("cordic result unexpected");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		dv_done |-> (state_q == S_DVW)) else $error("divider result unexpected");
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQW && sq_done && sq_root == 22'd0) |=>
		(state_q == S_DMUL && cnt_q == 2'd0)) else $error("zero magnitude not skipped");
`endif

endmodule
`default_nettype wire
